// ===== rtl/utf8_to_cp1252_transcoder_top_macros.svh =====
// Assertion macros shared by the transcoder RTL.
// Expects signals clk and rst_n in the scope of each use.
`ifndef UTF8_TO_CP1252_TRANSCODER_TOP_MACROS_SVH
`define UTF8_TO_CP1252_TRANSCODER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every enabled edge
`define UTF2CP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("utf2cp assertion failed");
// expression must never be true
`define UTF2CP_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("utf2cp forbidden condition");
`else
`define UTF2CP_ASSERT(lbl, prop)
`define UTF2CP_NEVER(lbl, expr)
`endif
`endif

// ===== rtl/utf2cp_pkg.sv =====
// Types, constants and the Windows-1252 reverse map for the transcoder.
// No dependencies.
package utf2cp_pkg;

  localparam logic [20:0] REPL_CP = 21'h00FFFD;

  // one queued job: replacements first, then an optional final result
  typedef struct packed {
    logic [1:0]  repl_cnt;
    logic        fin_vld;
    logic [20:0] fin_cp;
    logic        fin_bad;
    logic        fin_eot;
  } utf2cp_job_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] ansi;
  } utf2cp_map_t;

  function automatic utf2cp_map_t cp1252_map(input logic [20:0] cp);
    utf2cp_map_t m;
    m.ok   = 1'b1;
    m.ansi = cp[7:0];
    if (!(cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF))) begin
      case (cp)
        21'h020AC: m.ansi = 8'h80;
        21'h0201A: m.ansi = 8'h82;
        21'h00192: m.ansi = 8'h83;
        21'h0201E: m.ansi = 8'h84;
        21'h02026: m.ansi = 8'h85;
        21'h02020: m.ansi = 8'h86;
        21'h02021: m.ansi = 8'h87;
        21'h002C6: m.ansi = 8'h88;
        21'h02030: m.ansi = 8'h89;
        21'h00160: m.ansi = 8'h8A;
        21'h02039: m.ansi = 8'h8B;
        21'h00152: m.ansi = 8'h8C;
        21'h0017D: m.ansi = 8'h8E;
        21'h02018: m.ansi = 8'h91;
        21'h02019: m.ansi = 8'h92;
        21'h0201C: m.ansi = 8'h93;
        21'h0201D: m.ansi = 8'h94;
        21'h02022: m.ansi = 8'h95;
        21'h02013: m.ansi = 8'h96;
        21'h02014: m.ansi = 8'h97;
        21'h002DC: m.ansi = 8'h98;
        21'h02122: m.ansi = 8'h99;
        21'h00161: m.ansi = 8'h9A;
        21'h0203A: m.ansi = 8'h9B;
        21'h00153: m.ansi = 8'h9C;
        21'h0017E: m.ansi = 8'h9E;
        21'h00178: m.ansi = 8'h9F;
        default: begin
          m.ok   = 1'b0;
          m.ansi = 8'h00;
        end
      endcase
    end
    return m;
  endfunction

endpackage

// ===== rtl/utf2cp_front.sv =====
// Front end: accepts UTF-8 bytes, tracks the sequence state, builds jobs.
// Depends on utf2cp_pkg and the assertion macro header.
`include "utf8_to_cp1252_transcoder_top_macros.svh"
module utf2cp_front
  import utf2cp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        q_full,
  output logic        q_push,
  output utf2cp_job_t q_job
);

  logic [20:0] pp_r, pp_nxt, pp_shift;
  logic [1:0]  need_r, need_nxt;
  logic [1:0]  taken_r, taken_nxt;
  logic        accept;
  utf2cp_job_t job;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    pp_nxt    = pp_r;
    need_nxt  = need_r;
    taken_nxt = taken_r;
    pp_shift  = {pp_r[14:0], in_text_byte[5:0]};
    job       = '0;
    if (need_r != 2'd0 && in_text_byte[7:6] == 2'b10) begin
      pp_nxt    = pp_shift;
      need_nxt  = need_r - 2'd1;
      taken_nxt = taken_r + 2'd1;
      if (need_r == 2'd1) begin
        job.fin_vld = 1'b1;
        job.fin_cp  = pp_shift;
        pp_nxt      = '0;
        taken_nxt   = 2'd0;
      end
    end else begin
      // broken sequence: one for the lead plus one per continuation taken
      if (need_r != 2'd0) begin
        job.repl_cnt = (taken_r >= 2'd2) ? 2'd3 : 2'd1 + taken_r;
      end
      pp_nxt    = '0;
      need_nxt  = 2'd0;
      taken_nxt = 2'd0;
      if (in_text_byte == 8'h00) begin
        job.fin_vld = 1'b1;
        job.fin_eot = 1'b1;
      end else if (in_text_byte < 8'h80) begin
        job.fin_vld = 1'b1;
        job.fin_cp  = {13'd0, in_text_byte};
      end else if (in_text_byte inside {[8'hC0:8'hDF]}) begin
        pp_nxt   = {16'd0, in_text_byte[4:0]};
        need_nxt = 2'd1;
      end else if (in_text_byte inside {[8'hE0:8'hEF]}) begin
        pp_nxt   = {17'd0, in_text_byte[3:0]};
        need_nxt = 2'd2;
      end else if (in_text_byte inside {[8'hF0:8'hF7]}) begin
        pp_nxt   = {18'd0, in_text_byte[2:0]};
        need_nxt = 2'd3;
      end else begin
        job.fin_vld = 1'b1;
        job.fin_cp  = REPL_CP;
        job.fin_bad = 1'b1;
      end
    end
  end

  assign q_job  = job;
  assign q_push = accept && (job.repl_cnt != 2'd0 || job.fin_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r    <= '0;
      need_r  <= 2'd0;
      taken_r <= 2'd0;
    end else if (accept) begin
      pp_r    <= pp_nxt;
      need_r  <= need_nxt;
      taken_r <= taken_nxt;
    end
  end

  `UTF2CP_NEVER(a_idle_no_taken, need_r == 2'd0 && taken_r != 2'd0)
  `UTF2CP_NEVER(a_taken_max, taken_r == 2'd3)

endmodule

// ===== rtl/utf2cp_fifo.sv =====
// Short job queue between the front and back ends, flop based.
// Depends on utf2cp_pkg and the assertion macro header.
`include "utf8_to_cp1252_transcoder_top_macros.svh"
module utf2cp_fifo
  import utf2cp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  utf2cp_job_t push_job,
  input  logic        pop,
  output logic        full,
  output logic        head_vld,
  output utf2cp_job_t head_job
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  utf2cp_job_t   mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign head_vld = (cnt_r != '0);
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  `UTF2CP_NEVER(a_no_overflow, push && full)
  `UTF2CP_NEVER(a_no_underflow, pop && !head_vld)

endmodule

// ===== rtl/utf2cp_back.sv =====
// Back end: expands each job into result items, maps to Windows-1252,
// and holds the result in an output register. Depends on utf2cp_pkg.
`include "utf8_to_cp1252_transcoder_top_macros.svh"
module utf2cp_back
  import utf2cp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_vld,
  input  utf2cp_job_t head_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic [7:0]  out_ansi_byte,
  output logic        out_mappable,
  output logic        out_malformed,
  output logic        out_end_of_text,
  output logic        out_last_of_run
);

  logic [1:0]  cnt_r;
  logic [2:0]  total;
  logic        last, is_repl, emit, out_valid_r;
  logic [20:0] cp;
  logic        bad, eot;
  utf2cp_map_t map;

  logic [20:0] cp_r;
  logic [7:0]  ansi_r;
  logic        ok_r, bad_r, eot_r, last_r;

  assign total   = {1'b0, head_job.repl_cnt} + {2'b00, head_job.fin_vld};
  assign last    = ({1'b0, cnt_r} + 3'd1 == total);
  assign is_repl = (cnt_r < head_job.repl_cnt);
  assign emit    = head_vld && (!out_valid_r || out_ready);
  assign pop     = emit && last;

  always_comb begin
    cp  = is_repl ? REPL_CP : head_job.fin_cp;
    bad = is_repl ? 1'b1 : head_job.fin_bad;
    eot = is_repl ? 1'b0 : head_job.fin_eot;
    map = cp1252_map(cp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        cnt_r       <= last ? 2'd0 : cnt_r + 2'd1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cp_r   <= cp;
      ansi_r <= map.ansi;
      ok_r   <= map.ok;
      bad_r  <= bad;
      eot_r  <= eot;
      last_r <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_point  = cp_r;
  assign out_ansi_byte   = ansi_r;
  assign out_mappable    = ok_r;
  assign out_malformed   = bad_r;
  assign out_end_of_text = eot_r;
  assign out_last_of_run = last_r;

  `UTF2CP_NEVER(a_cnt_in_job, head_vld && {1'b0, cnt_r} >= total)

endmodule

// ===== rtl/utf8_to_cp1252_transcoder_top.sv =====
// UTF-8 to Windows-1252 transcoder, top level.
// Instantiates utf2cp_front, utf2cp_fifo and utf2cp_back; uses utf2cp_pkg.
// - Input channel (in_valid/in_ready/in_text_byte): one raw UTF-8 byte per
//   item. A zero byte ends the text and yields an end_of_text result.
// - Output channel (out_valid/out_ready/out_*): one decoded character per
//   item: code point, Windows-1252 byte and mappable flag, malformed flag
//   for U+FFFD replacements, and last_of_run on the final result of a byte.
// - A byte yields zero to four results. Lead bytes and inner continuations
//   yield none; a broken sequence yields its replacements plus the result
//   of the breaking byte.
// - Path: the job is queued at the accepting edge; the output register
//   loads it from the queue head once the back end is free to emit.
// - Throughput: one byte per cycle while each byte yields at most one
//   result and out_ready is high, as the back end then sends one result
//   per cycle; a byte with several results holds the back end longer,
//   and the QUEUE_DEPTH-job queue absorbs bursts before in_ready drops.
// - Receiver stall: the output register holds its item; the back end stops,
//   the queue fills, and in_ready falls once the queue is full.
// - Reset (rst_n low, synchronous): decoder state cleared, queue emptied,
//   no result pending.
module utf8_to_cp1252_transcoder_top
  import utf2cp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic [7:0]  out_ansi_byte,
  output logic        out_mappable,
  output logic        out_malformed,
  output logic        out_end_of_text,
  output logic        out_last_of_run
);

  logic        q_push, q_pop, q_full, q_head_vld;
  utf2cp_job_t q_job, q_head;

  // byte classification and sequence state
  utf2cp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  // decouples the byte rate from the result rate
  utf2cp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .full     (q_full),
    .head_vld (q_head_vld),
    .head_job (q_head)
  );

  // result expansion, code page lookup, output register
  utf2cp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_vld        (q_head_vld),
    .head_job        (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_point  (out_code_point),
    .out_ansi_byte   (out_ansi_byte),
    .out_mappable    (out_mappable),
    .out_malformed   (out_malformed),
    .out_end_of_text (out_end_of_text),
    .out_last_of_run (out_last_of_run)
  );

endmodule
